>>> hw/rtl/wadc_pkg.sv
// shared types, constants and register codes of the delta consistency monitor
`default_nettype none

package wadc_pkg;

   // field widths
   localparam int SAMPLE_BITS = 16;
   localparam int DELTA_W     = SAMPLE_BITS;
   localparam int SCORE_W     = 17;
   localparam int MEAN_W      = 24;
   localparam int NORM_W      = 16;
   localparam int HYST_W      = 16;
   localparam int COUNT_W     = 32;

   // window storage default
   localparam int MAX_WINDOW_DEFAULT = 64;

   // fixed point
   localparam int MEAN_FRAC  = 8;
   localparam int SCORE_FRAC = 16;
   localparam int HYST_FRAC  = 14;
   localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(65536);

   // window and scoring limits
   localparam int MIN_WINDOW = 4;
   localparam int MIN_OBS    = 2;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DELTAS        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMALIZER        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD         = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_HYSTERESIS  = 3'd4;

   // register reset values
   localparam logic [6:0]         WINDOW_LENGTH_RESET = 7'd16;
   localparam logic [6:0]         MIN_DELTAS_RESET    = 7'd2;
   localparam logic [NORM_W-1:0]  NORMALIZER_RESET    = 16'd1024;
   localparam logic [SCORE_W-1:0] THRESHOLD_RESET     = 17'd32768;
   localparam logic [HYST_W-1:0]  HYSTERESIS_RESET    = 16'd16384;

   // op codes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef struct packed {
      logic                          op;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [MEAN_W-1:0]  mean_abs_delta;
      logic               score_updated;
      logic               inconsistent;
      logic               went_inconsistent;
      logic               recovered;
      logic [COUNT_W-1:0] event_count;
      logic [COUNT_W-1:0] record_count;
   } rsp_type;

   typedef struct packed {
      logic               clear;
      logic               fetch;
      logic               push;
      logic [DELTA_W-1:0] delta;
   } ring_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/wadc_delta_ring.sv
// delta ring memory with head pointer, fill count and running sum
`default_nettype none

module wadc_delta_ring #(
   parameter int MAX_WINDOW = wadc_pkg::MAX_WINDOW_DEFAULT
) (
   input  wire logic                                                clock,
   input  wire logic                                                reset,
   input  wire wadc_pkg::ring_cmd_type                              cmd,
   input  wire logic [$clog2(MAX_WINDOW+1)-1:0]                     win,
   output logic      [$clog2(MAX_WINDOW+1)-1:0]                     fill,
   output logic      [wadc_pkg::DELTA_W+$clog2(MAX_WINDOW+1)-1:0]   sum
);

   localparam int HEAD_W = $clog2(MAX_WINDOW);
   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = wadc_pkg::DELTA_W + WIN_W;

   logic [wadc_pkg::DELTA_W-1:0] ring_ff [MAX_WINDOW];
   logic [wadc_pkg::DELTA_W-1:0] rdata_ff;

   logic [HEAD_W-1:0] head_ff, head_in;
   logic [WIN_W-1:0]  fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   logic [wadc_pkg::DELTA_W-1:0] old_delta;
   logic [WIN_W-1:0]             head_inc;

   // entries at or past the fill are not cleared, so they are read as zero
   always_comb begin
      old_delta = (fill_ff < win) ? '0 : rdata_ff;
      sum_in    = sum_ff - SUM_W'(old_delta) + SUM_W'(cmd.delta);
      head_inc  = WIN_W'(head_ff) + WIN_W'(1);
      head_in   = (head_inc >= win) ? '0 : HEAD_W'(head_inc);
      fill_in   = (fill_ff < win) ? fill_ff + WIN_W'(1) : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rdata_ff <= ring_ff[head_ff];
      end
      if (cmd.push) begin
         ring_ff[head_ff] <= cmd.delta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         head_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else if (cmd.push) begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   assign fill = fill_ff;
   assign sum  = sum_ff;

endmodule

`default_nettype wire

>>> hw/rtl/wadc_serial_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module wadc_serial_div #(
   parameter int DIV_W  = 32,
   parameter int DIVR_W = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [DIVR_W-1:0] divisor,
   output logic                   done,
   output logic      [DIV_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(DIV_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] dvs_ff;

   logic [DIVR_W:0]   trial;
   logic [DIVR_W:0]   trial_sub;
   logic              fits;

   // dividend bits shift out at the top while quotient bits shift in below
   always_comb begin
      trial     = {rem_ff, quo_ff[DIV_W-1]};
      fits      = trial >= {1'b0, dvs_ff};
      trial_sub = trial - {1'b0, dvs_ff};
      rem_in    = fits ? trial_sub[DIVR_W-1:0] : trial[DIVR_W-1:0];
      quo_in    = {quo_ff[DIV_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_W - 1);
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            quo_ff <= quo_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> hw/rtl/windowed_abs_delta_consistency_monitor_unit.sv
// top level of the windowed absolute delta consistency monitor
// sequence: a clear op or seeding sample goes from accept straight to the result push;
//   an unscored sample first passes update and check, and a scored sample then also runs
//   the shared bit-serial divider for the mean and then the ratio, one quotient bit a cycle
// flow: one beat at a time, requests stall until the result is loaded, longer while rsp_stall holds the result
// reset: synchronous; ring contents are gated by the fill count, no clearing pass
`default_nettype none

module windowed_abs_delta_consistency_monitor_unit #(
   parameter int MAX_WINDOW = wadc_pkg::MAX_WINDOW_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire wadc_pkg::req_type                    req_data,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output wadc_pkg::rsp_type                         rsp_data,
   // configuration write port
   input  wire logic                                 csr_we,
   input  wire logic [wadc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [wadc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = wadc_pkg::DELTA_W + WIN_W;
   // divider sized for the larger of the two divisions
   localparam int DIV_W  = (SUM_W + wadc_pkg::MEAN_FRAC > 32) ?
                           SUM_W + wadc_pkg::MEAN_FRAC : 32;
   localparam int DIVR_W = (WIN_W > wadc_pkg::NORM_W) ? WIN_W : wadc_pkg::NORM_W;
   localparam int PROD_W = wadc_pkg::SCORE_W + wadc_pkg::HYST_W;
   localparam int CMP_W  = PROD_W + 1;
   localparam int SB     = wadc_pkg::SAMPLE_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_CHECK,
      S_DIV_MEAN,
      S_DIV_RATIO,
      S_PUSH
   } state_type;

   // configuration registers
   logic [6:0]                      window_length_ff;
   logic [6:0]                      min_deltas_ff;
   logic [wadc_pkg::NORM_W-1:0]     normalizer_ff;
   logic [wadc_pkg::SCORE_W-1:0]    threshold_ff;
   logic [wadc_pkg::HYST_W-1:0]     hysteresis_ff;
   logic [PROD_W-1:0]               recover_level_ff;

   // monitor state
   state_type                       state_ff;
   logic signed [SB-1:0]            prev_sample_ff;
   logic                            seeded_ff;
   logic [wadc_pkg::SCORE_W-1:0]    last_score_ff;
   logic [wadc_pkg::MEAN_W-1:0]     last_mean_ff;
   logic                            was_inconsistent_ff;
   logic [wadc_pkg::COUNT_W-1:0]    onset_count_ff;
   logic [wadc_pkg::COUNT_W-1:0]    record_count_ff;
   logic                            updated_ff;
   logic                            rise_ff;
   logic                            recov_ff;
   logic                            rsp_valid_ff;

   // payload registers
   logic [wadc_pkg::DELTA_W-1:0]    delta_ff;
   wadc_pkg::rsp_type               rsp_data_ff;

   // combinational
   logic                            req_accept;
   logic                            csr_hit;
   logic                            rsp_load;
   logic [WIN_W-1:0]                win;
   logic [31:0]                     wl_ext;
   logic [31:0]                     minobs;
   logic                            enough;
   logic [wadc_pkg::NORM_W-1:0]     norm_eff;
   logic signed [SB:0]              diff;
   logic [SB:0]                     diff_neg;
   logic [wadc_pkg::DELTA_W-1:0]    delta_abs;
   logic [wadc_pkg::SCORE_W-1:0]    score_new;
   logic                            now_inconsistent;
   logic                            recover_margin;

   wadc_pkg::ring_cmd_type          ring_cmd;
   logic [WIN_W-1:0]                ring_fill;
   logic [SUM_W-1:0]                ring_sum;

   logic                            div_start;
   logic [DIV_W-1:0]                div_dividend;
   logic [DIVR_W-1:0]               div_divisor;
   logic                            div_done;
   logic [DIV_W-1:0]                div_quotient;

   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   // result register frees up when empty or when its beat is taken
   assign rsp_load   = (state_ff == S_PUSH) && (!rsp_valid_ff || !rsp_stall);

   // only listed registers are stored, and only they clear the state
   always_comb begin
      unique case (csr_index)
         wadc_pkg::CSR_WINDOW_LENGTH,
         wadc_pkg::CSR_MIN_DELTAS,
         wadc_pkg::CSR_NORMALIZER,
         wadc_pkg::CSR_THRESHOLD,
         wadc_pkg::CSR_CLEAR_HYSTERESIS: csr_hit = csr_we;
         default:                        csr_hit = 1'b0;
      endcase
   end

   // effective window clamped to [4, MAX_WINDOW]
   always_comb begin
      wl_ext = 32'(window_length_ff);
      if (wl_ext < 32'(wadc_pkg::MIN_WINDOW)) begin
         win = WIN_W'(wadc_pkg::MIN_WINDOW);
      end else if (wl_ext > 32'(MAX_WINDOW)) begin
         win = WIN_W'(MAX_WINDOW);
      end else begin
         win = WIN_W'(window_length_ff);
      end
   end

   // scoring starts once the fill reaches max(2, minimum delta count)
   always_comb begin
      minobs = (32'(min_deltas_ff) > 32'(wadc_pkg::MIN_OBS)) ?
               32'(min_deltas_ff) : 32'(wadc_pkg::MIN_OBS);
      enough = 32'(ring_fill) >= minobs;
   end

   assign norm_eff = (normalizer_ff == '0) ? wadc_pkg::NORM_W'(1) : normalizer_ff;

   // absolute delta, one bit wider for the signed difference
   always_comb begin
      diff      = {req_data.sample[SB-1], req_data.sample} -
                  {prev_sample_ff[SB-1], prev_sample_ff};
      diff_neg  = -diff;
      delta_abs = diff[SB] ? diff_neg[SB-1:0] : diff[SB-1:0];
   end

   // ring commands
   always_comb begin
      ring_cmd.clear = csr_hit || (req_accept && (req_data.op == wadc_pkg::OP_CLEAR));
      ring_cmd.fetch = req_accept;
      ring_cmd.push  = (state_ff == S_UPDATE);
      ring_cmd.delta = delta_ff;
   end

   // divider operands: sum by fill, then mean by normalizer
   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIV_W'(ring_sum) << wadc_pkg::MEAN_FRAC;
      div_divisor  = DIVR_W'(ring_fill);
      if (state_ff == S_CHECK) begin
         div_start = enough;
      end else if (state_ff == S_DIV_MEAN) begin
         div_start    = div_done;
         div_dividend = DIV_W'(div_quotient[wadc_pkg::MEAN_W-1:0]) << wadc_pkg::MEAN_FRAC;
         div_divisor  = DIVR_W'(norm_eff);
      end
   end

   // score from the ratio quotient, floored at zero
   always_comb begin
      if (|div_quotient[DIV_W-1:wadc_pkg::SCORE_FRAC]) begin
         score_new = '0;
      end else begin
         score_new = wadc_pkg::SCORE_ONE -
                     wadc_pkg::SCORE_W'(div_quotient[wadc_pkg::SCORE_FRAC-1:0]);
      end
      now_inconsistent = score_new < threshold_ff;
      recover_margin   = (CMP_W'(score_new) << wadc_pkg::HYST_FRAC) >
                         CMP_W'(recover_level_ff);
   end

   wadc_delta_ring #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (ring_cmd),
      .win   (win),
      .fill  (ring_fill),
      .sum   (ring_sum)
   );

   wadc_serial_div #(
      .DIV_W  (DIV_W),
      .DIVR_W (DIVR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= wadc_pkg::WINDOW_LENGTH_RESET;
         min_deltas_ff    <= wadc_pkg::MIN_DELTAS_RESET;
         normalizer_ff    <= wadc_pkg::NORMALIZER_RESET;
         threshold_ff     <= wadc_pkg::THRESHOLD_RESET;
         hysteresis_ff    <= wadc_pkg::HYSTERESIS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            wadc_pkg::CSR_WINDOW_LENGTH:    window_length_ff <= csr_wdata[6:0];
            wadc_pkg::CSR_MIN_DELTAS:       min_deltas_ff    <= csr_wdata[6:0];
            wadc_pkg::CSR_NORMALIZER:       normalizer_ff    <= csr_wdata[wadc_pkg::NORM_W-1:0];
            wadc_pkg::CSR_THRESHOLD:        threshold_ff     <= csr_wdata[wadc_pkg::SCORE_W-1:0];
            wadc_pkg::CSR_CLEAR_HYSTERESIS: hysteresis_ff    <= csr_wdata[wadc_pkg::HYST_W-1:0];
            default: ;
         endcase
      end
   end

   // recovery level follows the registers in the next cycle, long before any score
   always_ff @(posedge clock) begin
      recover_level_ff <= PROD_W'(threshold_ff) * PROD_W'(hysteresis_ff);
   end

   // sequencer and monitor state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_IDLE;
         prev_sample_ff      <= '0;
         seeded_ff           <= 1'b0;
         last_score_ff       <= wadc_pkg::SCORE_ONE;
         last_mean_ff        <= '0;
         was_inconsistent_ff <= 1'b0;
         onset_count_ff      <= '0;
         record_count_ff     <= '0;
         updated_ff          <= 1'b0;
         rise_ff             <= 1'b0;
         recov_ff            <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         // a new result replaces the taken one in the same cycle
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_hit) begin
            // config write clears like the clear op, without a result
            prev_sample_ff      <= '0;
            seeded_ff           <= 1'b0;
            last_score_ff       <= wadc_pkg::SCORE_ONE;
            last_mean_ff        <= '0;
            was_inconsistent_ff <= 1'b0;
            onset_count_ff      <= '0;
            record_count_ff     <= '0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  updated_ff <= 1'b0;
                  rise_ff    <= 1'b0;
                  recov_ff   <= 1'b0;
                  if (req_data.op == wadc_pkg::OP_CLEAR) begin
                     prev_sample_ff      <= '0;
                     seeded_ff           <= 1'b0;
                     last_score_ff       <= wadc_pkg::SCORE_ONE;
                     last_mean_ff        <= '0;
                     was_inconsistent_ff <= 1'b0;
                     onset_count_ff      <= '0;
                     record_count_ff     <= '0;
                     state_ff            <= S_PUSH;
                  end else begin
                     if (record_count_ff != '1) begin
                        record_count_ff <= record_count_ff + wadc_pkg::COUNT_W'(1);
                     end
                     prev_sample_ff <= req_data.sample;
                     seeded_ff      <= 1'b1;
                     // first sample after a clear only seeds
                     state_ff       <= seeded_ff ? S_UPDATE : S_PUSH;
                  end
               end
            end
            S_UPDATE: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               state_ff <= enough ? S_DIV_MEAN : S_PUSH;
            end
            S_DIV_MEAN: begin
               if (div_done) begin
                  last_mean_ff <= div_quotient[wadc_pkg::MEAN_W-1:0];
                  state_ff     <= S_DIV_RATIO;
               end
            end
            S_DIV_RATIO: begin
               if (div_done) begin
                  last_score_ff       <= score_new;
                  updated_ff          <= 1'b1;
                  was_inconsistent_ff <= now_inconsistent;
                  if (now_inconsistent && !was_inconsistent_ff) begin
                     rise_ff <= 1'b1;
                     if (onset_count_ff != '1) begin
                        onset_count_ff <= onset_count_ff + wadc_pkg::COUNT_W'(1);
                     end
                  end else if (!now_inconsistent && was_inconsistent_ff && recover_margin) begin
                     recov_ff <= 1'b1;
                  end
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // delta and result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         delta_ff <= delta_abs;
      end
      if (rsp_load) begin
         rsp_data_ff.score             <= last_score_ff;
         rsp_data_ff.mean_abs_delta    <= last_mean_ff;
         rsp_data_ff.score_updated     <= updated_ff;
         rsp_data_ff.inconsistent      <= was_inconsistent_ff;
         rsp_data_ff.went_inconsistent <= rise_ff;
         rsp_data_ff.recovered         <= recov_ff;
         rsp_data_ff.event_count       <= onset_count_ff;
         rsp_data_ff.record_count      <= record_count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // an accepted beat holds off the next one
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("req beat accepted without stalling the next");

   // divider finishes only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_MEAN || state_ff == S_DIV_RATIO))
      else $error("divider done outside a division state");

   // an onset pulse comes with a fresh score and a raised flag
   a_onset_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.went_inconsistent) |->
         (rsp_data.inconsistent && rsp_data.score_updated && !rsp_data.recovered))
      else $error("onset pulse without score update or flag");

   // a recovery pulse comes with a fresh score and a cleared flag
   a_recover_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.recovered) |->
         (!rsp_data.inconsistent && rsp_data.score_updated))
      else $error("recovery pulse without score update or with flag set");
`endif

endmodule

`default_nettype wire

>>> bench/wadc_consistency_checker.sv
// result checker for the delta consistency monitor: predicts every result beat and compares it
module wadc_consistency_checker #(
   parameter int MAX_WINDOW = wadc_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  wadc_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  wadc_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [wadc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wadc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               pending_beats,
   output int                               mismatches,
   output int                               checked_beats,
   output int                               scored_beats,
   output int                               onset_beats,
   output int                               recovery_beats
);
   timeunit 1ns;
   timeprecision 1ps;

   // register copies
   logic [6:0]                   cfg_window;
   logic [6:0]                   cfg_min;
   logic [wadc_pkg::NORM_W-1:0]  cfg_norm;
   logic [wadc_pkg::SCORE_W-1:0] cfg_thr;
   logic [wadc_pkg::HYST_W-1:0]  cfg_hyst;

   // monitor state
   logic signed [wadc_pkg::SAMPLE_BITS-1:0] prev_sample;
   bit                                      have_prev;
   logic [wadc_pkg::DELTA_W-1:0]            delta_hist [MAX_WINDOW];
   int unsigned                             hist_head;
   int unsigned                             hist_fill;
   logic [22:0]                             delta_total;
   logic [wadc_pkg::SCORE_W-1:0]            held_score;
   logic [wadc_pkg::MEAN_W-1:0]             held_mean;
   bit                                      flagged;
   logic [wadc_pkg::COUNT_W-1:0]            onsets;
   logic [wadc_pkg::COUNT_W-1:0]            records;

   wadc_pkg::rsp_type predicted_beats [$];
   int      error_total = 0;
   int      seen_total = 0;
   int      scored_total = 0;
   int      onset_total = 0;
   int      recov_total = 0;

   assign mismatches     = error_total;
   assign checked_beats  = seen_total;
   assign scored_beats   = scored_total;
   assign onset_beats    = onset_total;
   assign recovery_beats = recov_total;

   task automatic clear_monitor();
      prev_sample = '0;
      have_prev   = 1'b0;
      foreach (delta_hist[i]) delta_hist[i] = '0;
      hist_head   = 0;
      hist_fill   = 0;
      delta_total = '0;
      held_score  = wadc_pkg::SCORE_ONE;
      held_mean   = '0;
      flagged     = 1'b0;
      onsets      = '0;
      records     = '0;
   endtask

   task automatic predict_beat(input wadc_pkg::req_type beat, output wadc_pkg::rsp_type res);
      int unsigned win;
      int unsigned slot;
      int unsigned need;
      int          d;
      logic [wadc_pkg::DELTA_W-1:0] delta;
      logic [63:0] mean_q8;
      logic [63:0] ratio;
      logic [63:0] norm;
      logic [63:0] new_score;
      bit now_bad;
      bit updated;
      bit rise;
      bit recov;
      updated = 1'b0;
      rise    = 1'b0;
      recov   = 1'b0;
      if (beat.op == wadc_pkg::OP_CLEAR) begin
         clear_monitor();
      end else begin
         if (records != '1) records++;
         if (!have_prev) begin
            prev_sample = beat.sample;
            have_prev   = 1'b1;
         end else begin
            win = (32'(cfg_window) < wadc_pkg::MIN_WINDOW) ? wadc_pkg::MIN_WINDOW :
                  (32'(cfg_window) > MAX_WINDOW) ? MAX_WINDOW : 32'(cfg_window);
            d = int'($signed(beat.sample)) - int'(prev_sample);
            delta = wadc_pkg::DELTA_W'((d < 0) ? -d : d);
            slot = (hist_head < win) ? hist_head : 0;
            need = (32'(cfg_min) > wadc_pkg::MIN_OBS) ? 32'(cfg_min) : wadc_pkg::MIN_OBS;
            prev_sample = beat.sample;
            delta_total = delta_total - 23'(delta_hist[slot]) + 23'(delta);
            delta_hist[slot] = delta;
            hist_head = (slot + 1 >= win) ? 0 : slot + 1;
            if (hist_fill < win) hist_fill++;
            if (hist_fill >= need) begin
               norm = (cfg_norm == '0) ? 64'd1 : 64'(cfg_norm);
               mean_q8 = (64'(delta_total) << wadc_pkg::MEAN_FRAC) / 64'(hist_fill);
               ratio = (mean_q8 << (wadc_pkg::SCORE_FRAC - wadc_pkg::MEAN_FRAC)) / norm;
               new_score = (ratio >= 64'(wadc_pkg::SCORE_ONE)) ? 64'd0 :
                           64'(wadc_pkg::SCORE_ONE) - ratio;
               now_bad = new_score < 64'(cfg_thr);
               updated = 1'b1;
               held_mean  = wadc_pkg::MEAN_W'(mean_q8);
               held_score = wadc_pkg::SCORE_W'(new_score);
               if (now_bad && !flagged) begin
                  rise = 1'b1;
                  if (onsets != '1) onsets++;
               end else if (!now_bad && flagged &&
                            (new_score << wadc_pkg::HYST_FRAC) >
                            64'(cfg_thr) * 64'(cfg_hyst)) begin
                  recov = 1'b1;
               end
               flagged = now_bad;
            end
         end
      end
      res.score             = held_score;
      res.mean_abs_delta    = held_mean;
      res.score_updated     = updated;
      res.inconsistent      = flagged;
      res.went_inconsistent = rise;
      res.recovered         = recov;
      res.event_count       = onsets;
      res.record_count      = records;
   endtask

   task automatic check_field(input string fname, input logic [63:0] want, got);
      if (got !== want) begin
         if (error_total < 10)
            $display("beat %0d %s: expected %0h, got %0h", seen_total, fname, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      wadc_pkg::rsp_type want;
      wadc_pkg::rsp_type pred;
      bit                listed;
      if (reset) begin
         cfg_window = wadc_pkg::WINDOW_LENGTH_RESET;
         cfg_min    = wadc_pkg::MIN_DELTAS_RESET;
         cfg_norm   = wadc_pkg::NORMALIZER_RESET;
         cfg_thr    = wadc_pkg::THRESHOLD_RESET;
         cfg_hyst   = wadc_pkg::HYSTERESIS_RESET;
         clear_monitor();
         predicted_beats.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_beats.size() == 0) begin
               if (error_total < 10)
                  $display("beat %0d: result with nothing outstanding", seen_total);
               error_total++;
            end else begin
               want = predicted_beats.pop_front();
               check_field("score", 64'(want.score), 64'(rsp_data.score));
               check_field("mean_abs_delta", 64'(want.mean_abs_delta),
                           64'(rsp_data.mean_abs_delta));
               check_field("score_updated", 64'(want.score_updated),
                           64'(rsp_data.score_updated));
               check_field("inconsistent", 64'(want.inconsistent),
                           64'(rsp_data.inconsistent));
               check_field("went_inconsistent", 64'(want.went_inconsistent),
                           64'(rsp_data.went_inconsistent));
               check_field("recovered", 64'(want.recovered), 64'(rsp_data.recovered));
               check_field("event_count", 64'(want.event_count), 64'(rsp_data.event_count));
               check_field("record_count", 64'(want.record_count),
                           64'(rsp_data.record_count));
               if (want.score_updated) scored_total++;
               if (want.went_inconsistent) onset_total++;
               if (want.recovered) recov_total++;
            end
            seen_total++;
         end
         if (csr_we) begin
            // unlisted indexes are ignored and leave the state alone
            listed = 1'b1;
            case (csr_index)
               wadc_pkg::CSR_WINDOW_LENGTH:    cfg_window = csr_wdata[6:0];
               wadc_pkg::CSR_MIN_DELTAS:       cfg_min    = csr_wdata[6:0];
               wadc_pkg::CSR_NORMALIZER:       cfg_norm   = csr_wdata[wadc_pkg::NORM_W-1:0];
               wadc_pkg::CSR_THRESHOLD:        cfg_thr    = csr_wdata[wadc_pkg::SCORE_W-1:0];
               wadc_pkg::CSR_CLEAR_HYSTERESIS: cfg_hyst   = csr_wdata[wadc_pkg::HYST_W-1:0];
               default:                        listed     = 1'b0;
            endcase
            if (listed) clear_monitor();
         end
         if (req_valid && !req_stall) begin
            predict_beat(req_data, pred);
            predicted_beats.push_back(pred);
         end
      end
      pending_beats <= predicted_beats.size();
   end

endmodule

>>> bench/tb.sv
// top of the delta consistency monitor testbench: clock, reset, stimulus and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // run limits and timing knobs
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int HOLDOFF_CYCLES = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_BEATS    = 205;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   wadc_pkg::req_type                req_data = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   wadc_pkg::rsp_type                rsp_data;
   logic                             csr_we = 1'b0;
   logic [wadc_pkg::CSR_INDEX_W-1:0] csr_index = wadc_pkg::CSR_WINDOW_LENGTH;
   logic [wadc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int pending_beats;
   int mismatches;
   int checked_beats;
   int scored_beats;
   int onset_beats;
   int recovery_beats;

   // idle rates in percent; the receiver ones are read by its own process
   int tx_idle_pct = 20;
   int rx_idle_pct = 20;
   bit holdoff_go = 1'b0;
   bit holdoff_done = 1'b0;
   int hold_cycles = 0;
   int cycle_count = 0;
   int settings_used = 1;
   int clears_sent = 0;

   always #4 clock = ~clock;

   windowed_abs_delta_consistency_monitor_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wadc_consistency_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pending_beats  (pending_beats),
      .mismatches     (mismatches),
      .checked_beats  (checked_beats),
      .scored_beats   (scored_beats),
      .onset_beats    (onset_beats),
      .recovery_beats (recovery_beats)
   );

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, pending_beats);
         $display("windowed_abs_delta_consistency_monitor_unit: mismatch");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off so the block backs up
   // and has to stall the request side while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles != 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (holdoff_go && !holdoff_done) begin
         rsp_stall <= 1'b1;
         hold_cycles <= HOLDOFF_CYCLES;
         holdoff_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // offer one request beat, maybe after a gap, and return at the edge that takes it;
   // valid stays high on exit so back-to-back beats need no second write in a step
   task automatic send_beat(input logic op,
                            input logic signed [wadc_pkg::SAMPLE_BITS-1:0] value);
      wadc_pkg::req_type beat;
      beat.op = op;
      beat.sample = value;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      if (op == wadc_pkg::OP_CLEAR) clears_sent++;
   endtask

   // drop valid and wait until every predicted beat has come back, then let the
   // block go quiet before registers are touched
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_beats != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [wadc_pkg::CSR_INDEX_W-1:0] idx,
                          input int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wadc_pkg::CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   // every write clears the monitor, so all five go in together before a phase
   task automatic program_regs(input int unsigned win, mins, norm, thr, hyst);
      put_reg(wadc_pkg::CSR_WINDOW_LENGTH, win);
      put_reg(wadc_pkg::CSR_MIN_DELTAS, mins);
      put_reg(wadc_pkg::CSR_NORMALIZER, norm);
      put_reg(wadc_pkg::CSR_THRESHOLD, thr);
      put_reg(wadc_pkg::CSR_CLEAR_HYSTERESIS, hyst);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int unsigned win;
      int unsigned mins;
      int unsigned norm;
      int unsigned thr;
      int unsigned hyst;
      int walk;
      int lim;
      int burst_left;
      int step;
      logic signed [wadc_pkg::SAMPLE_BITS-1:0] value;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: clear with a full-scale sample, then full-swing deltas
      // drive the score to zero and raise the flag
      send_beat(wadc_pkg::OP_CLEAR, 16'sh7FFF);
      send_beat(wadc_pkg::OP_RECORD, 16'sh8000);
      send_beat(wadc_pkg::OP_RECORD, 16'sh7FFF);
      send_beat(wadc_pkg::OP_RECORD, 16'sh8000);

      // window below four, zero normalizer, threshold above one: always inconsistent;
      // clear op in the middle of a stream
      settle();
      program_regs(0, 0, 0, 131071, 0);
      send_beat(wadc_pkg::OP_RECORD, 16'sh0000);
      send_beat(wadc_pkg::OP_RECORD, 16'sh0000);
      send_beat(wadc_pkg::OP_RECORD, -16'sd1);
      send_beat(wadc_pkg::OP_CLEAR, 16'sh5A5A);
      send_beat(wadc_pkg::OP_RECORD, 16'sd5);

      // window above the storage, min samples at the top, widest normalizer
      settle();
      program_regs(127, 64, 65535, 0, 65535);
      send_beat(wadc_pkg::OP_RECORD, 16'sd100);
      send_beat(wadc_pkg::OP_RECORD, -16'sd100);

      // min samples beyond the window: never scores, score stays at one
      settle();
      program_regs(4, 127, 8, 65536, 16384);
      send_beat(wadc_pkg::OP_RECORD, 16'sd0);
      send_beat(wadc_pkg::OP_RECORD, 16'sd16);
      send_beat(wadc_pkg::OP_RECORD, 16'sd32);

      // one spike in a four-deep window: flag rises, then falls when the spike
      // leaves; with 1.5x hysteresis the fall has too little margin for a recovery
      settle();
      program_regs(4, 2, 256, 49152, 24576);
      send_beat(wadc_pkg::OP_RECORD, 16'sd0);
      repeat (5) send_beat(wadc_pkg::OP_RECORD, 16'sd1024);

      // same spike with unity hysteresis: the fall reports a recovery
      settle();
      program_regs(4, 2, 256, 49152, 16384);
      send_beat(wadc_pkg::OP_RECORD, 16'sd0);
      repeat (5) send_beat(wadc_pkg::OP_RECORD, 16'sd1024);

      // random phases: bursts of random walk whose step size is set against the
      // normalizer, so the score swings between calm and noisy and the flag toggles
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         win  = ($urandom_range(7) == 0) ? $urandom_range(0, 127) : $urandom_range(4, 64);
         mins = ($urandom_range(7) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 8);
         norm = $urandom_range(1, 65535) >> $urandom_range(0, 15);
         thr  = ($urandom_range(9) == 0) ? $urandom_range(65537, 131071)
                                         : $urandom_range(0, 65536);
         hyst = ($urandom_range(4) == 0) ? $urandom_range(0, 65535)
                                         : $urandom_range(8192, 32768);
         if (ph == 0) win = 64;
         if (ph == 1) win = 4;
         program_regs(win, mins, norm, thr, hyst);

         // one phase runs with both sides flat out
         tx_idle_pct = (ph == 2) ? 0 : 20;
         rx_idle_pct <= (ph == 2) ? 0 : 20;

         if (norm == 0) norm = 1;
         walk = 0;
         burst_left = 0;
         lim = 0;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (ph == 4 && n == 40) holdoff_go <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(4, 140);
               case ($urandom_range(0, 6))
                  0: lim = 0;
                  1: lim = int'(norm / 4);
                  2: lim = int'(norm);
                  3: lim = int'(norm) * 3;
                  4: lim = int'(norm * $urandom_range(1, 12) / 4);
                  5: lim = 65535;
                  default: lim = -1;   // raw full-range samples
               endcase
               if (lim > 65535) lim = 65535;
            end
            burst_left--;
            if (lim < 0) begin
               walk = int'($signed(16'($urandom)));
            end else begin
               step = int'($urandom_range(0, 2 * lim)) - lim;
               walk = walk + step;
               if (walk > 32767) walk = 32767;
               if (walk < -32768) walk = -32768;
            end
            value = wadc_pkg::SAMPLE_BITS'(walk);
            if ($urandom_range(99) < 2)
               send_beat(wadc_pkg::OP_CLEAR, wadc_pkg::SAMPLE_BITS'($urandom));
            else
               send_beat(wadc_pkg::OP_RECORD, value);
         end
      end

      settle();
      $display("covered %0d result beats over %0d register settings", checked_beats,
               settings_used);
      $display("%0d scored, %0d onsets, %0d recoveries, %0d clear ops, one long result hold-off",
               scored_beats, onset_beats, recovery_beats, clears_sent);
      if (mismatches == 0)
         $display("windowed_abs_delta_consistency_monitor_unit: match");
      else
         $display("windowed_abs_delta_consistency_monitor_unit: mismatch");
      $finish;
   end

endmodule
